// ----- hdl/ladsr_pkg.sv -----
// Shared constants and types for the linear ADSR envelope block.
package ladsr_pkg;

  localparam int SAMPLE_BITS_DEF         = 24;
  localparam int LEVEL_FRACTION_BITS_DEF = 23;
  localparam int CFG_INDEX_BITS          = 3;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE  = 3'd0,
    REG_ATTACK  = 3'd1,
    REG_DECAY   = 3'd2,
    REG_SUSTAIN = 3'd3,
    REG_RELEASE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    phase_t phase;
    logic   stopped;
  } env_status_t;

endpackage

// ----- hdl/ladsr_in_if.sv -----
// Input item channel: one audio sample with note flags.
interface ladsr_in_if #(
  parameter int SAMPLE_BITS = ladsr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          note_start;
  logic                          note_release;

  modport source (output valid, output sample_in, output note_start, output note_release,
                  input ready);
  modport sink   (input valid, input sample_in, input note_start, input note_release,
                  output ready);
endinterface

// ----- hdl/ladsr_out_if.sv -----
// Result item channel: shaped sample with envelope level, phase and stop flag.
interface ladsr_out_if #(
  parameter int SAMPLE_BITS         = ladsr_pkg::SAMPLE_BITS_DEF,
  parameter int LEVEL_FRACTION_BITS = ladsr_pkg::LEVEL_FRACTION_BITS_DEF
);
  import ladsr_pkg::*;

  logic                              valid;
  logic                              ready;
  logic signed [SAMPLE_BITS-1:0]     sample_out;
  logic [LEVEL_FRACTION_BITS:0]      envelope_level;
  phase_t                            envelope_phase;
  logic                              voice_stopped;

  modport source (output valid, output sample_out, output envelope_level,
                  output envelope_phase, output voice_stopped, input ready);
  modport sink   (input valid, input sample_out, input envelope_level,
                  input envelope_phase, input voice_stopped, output ready);
endinterface

// ----- hdl/ladsr_env.sv -----
// Envelope state: level and phase, advanced once per accepted item.
module ladsr_env #(
  parameter int LEVEL_FRACTION_BITS = ladsr_pkg::LEVEL_FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         note_start,
  input  logic                         note_release,
  input  logic                         enable,
  input  logic [LEVEL_FRACTION_BITS:0] attack_step,
  input  logic [LEVEL_FRACTION_BITS:0] decay_step,
  input  logic [LEVEL_FRACTION_BITS:0] sustain_level,
  input  logic [LEVEL_FRACTION_BITS:0] release_step,
  output logic [LEVEL_FRACTION_BITS:0] level,
  output ladsr_pkg::env_status_t       status
);
  import ladsr_pkg::*;

  localparam int LW = LEVEL_FRACTION_BITS + 1;
  localparam logic [LW-1:0] FULL = {1'b1, {LEVEL_FRACTION_BITS{1'b0}}};

  logic [LW-1:0]        sus;
  phase_t               phase_in;
  logic [LW:0]          att_sum;
  logic signed [LW:0]   dec_diff;
  logic signed [LW:0]   rel_diff;
  logic [LW-1:0]        level_next;
  phase_t               phase_next;
  logic                 stopped_next;

  assign sus      = (sustain_level > FULL) ? FULL : sustain_level;
  assign phase_in = note_release ? PH_RELEASE : (note_start ? PH_ATTACK : status.phase);
  assign att_sum  = {1'b0, level} + {1'b0, attack_step};
  assign dec_diff = $signed({1'b0, level}) - $signed({1'b0, decay_step});
  assign rel_diff = $signed({1'b0, level}) - $signed({1'b0, release_step});

  always_comb begin
    level_next   = level;
    phase_next   = phase_in;
    stopped_next = 1'b0;
    if (enable) begin
      case (phase_in)
        PH_ATTACK: begin
          if (att_sum >= {1'b0, FULL}) begin
            level_next = FULL;
            phase_next = PH_DECAY;
          end else begin
            level_next = att_sum[LW-1:0];
          end
        end
        PH_DECAY: begin
          if (dec_diff <= $signed({1'b0, sus})) begin
            level_next = sus;
            phase_next = PH_SUSTAIN;
          end else begin
            level_next = dec_diff[LW-1:0];
          end
        end
        PH_SUSTAIN: begin
          level_next = sus;
        end
        PH_RELEASE: begin
          if (rel_diff[LW] || rel_diff == '0) begin
            level_next   = '0;
            phase_next   = PH_OFF;
            stopped_next = 1'b1;
          end else begin
            level_next = rel_diff[LW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level          <= '0;
      status.phase   <= PH_OFF;
      status.stopped <= 1'b0;
    end else if (accept) begin
      level          <= level_next;
      status.phase   <= phase_next;
      status.stopped <= stopped_next;
    end
  end

  a_attack_rises: assert property (@(posedge clk) disable iff (rst)
    accept && enable && !note_release && (note_start || status.phase == PH_ATTACK)
      |=> level >= $past(level))
    else $error("level fell during attack");

  a_disabled_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !enable |=> level == $past(level))
    else $error("level moved with envelope disabled");

  a_stop_at_zero: assert property (@(posedge clk) disable iff (rst)
    status.stopped |-> level == '0 && status.phase == PH_OFF)
    else $error("voice stop without zero level and off phase");

endmodule

// ----- hdl/linear_adsr_envelope.sv -----
// Linear ADSR envelope generator, top level.
// Takes one sample item per clock cycle unless stalled and returns one result
// item per item via the first-stage and output registers. Level and phase
// advance in the cycle the item is accepted (add or subtract, clamp, phase
// change); the following stage multiplies the sample by the new level and shifts
// right by LEVEL_FRACTION_BITS, rounding toward minus infinity, or passes the
// sample unchanged while disabled. The single multiplier sets the clock limit.
// Input ready drops only while a result waits in the output register and the
// sink holds it. The user must write configuration through cfg_write/cfg_index/
// cfg_data only while no item is in flight (the block does not enforce this); configuration resets to zero.
module linear_adsr_envelope #(
  parameter int SAMPLE_BITS         = ladsr_pkg::SAMPLE_BITS_DEF,
  parameter int LEVEL_FRACTION_BITS = ladsr_pkg::LEVEL_FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ladsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LEVEL_FRACTION_BITS:0]         cfg_data,
  ladsr_in_if.sink                             din,
  ladsr_out_if.source                          dout
);
  import ladsr_pkg::*;

  localparam int LW = LEVEL_FRACTION_BITS + 1;
  localparam int PW = SAMPLE_BITS + LW + 1;

  logic                          enable;
  logic [LW-1:0]                 attack_step;
  logic [LW-1:0]                 decay_step;
  logic [LW-1:0]                 sustain_level;
  logic [LW-1:0]                 release_step;

  logic                          adv;
  logic                          accept;
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic [LW-1:0]                 level;
  env_status_t                   status;

  logic signed [LW:0]            lv;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          shifted;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic [LW-1:0]                 out_level;
  phase_t                        out_phase;
  logic                          out_stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      attack_step   <= '0;
      decay_step    <= '0;
      sustain_level <= '0;
      release_step  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE:  enable        <= cfg_data[0];
        REG_ATTACK:  attack_step   <= cfg_data;
        REG_DECAY:   decay_step    <= cfg_data;
        REG_SUSTAIN: sustain_level <= cfg_data;
        REG_RELEASE: release_step  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign adv       = !out_valid || dout.ready;
  assign accept    = din.valid && adv;
  assign din.ready = adv;

  ladsr_env #(
    .LEVEL_FRACTION_BITS(LEVEL_FRACTION_BITS)
  ) u_env (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .note_start   (din.note_start),
    .note_release (din.note_release),
    .enable       (enable),
    .attack_step  (attack_step),
    .decay_step   (decay_step),
    .sustain_level(sustain_level),
    .release_step (release_step),
    .level        (level),
    .status       (status)
  );

  assign lv      = $signed({1'b0, level});
  assign prod    = s1_sample * lv;
  assign shifted = prod >>> LEVEL_FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= din.valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample   <= din.sample_in;
      out_sample  <= enable ? shifted[SAMPLE_BITS-1:0] : s1_sample;
      out_level   <= level;
      out_phase   <= status.phase;
      out_stopped <= status.stopped;
    end
  end

  assign dout.valid          = out_valid;
  assign dout.sample_out     = out_sample;
  assign dout.envelope_level = out_level;
  assign dout.envelope_phase = out_phase;
  assign dout.voice_stopped  = out_stopped;

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid)
    else $error("item dropped from first stage while stalled");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv |=> out_valid)
    else $error("item lost between stages");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv && !enable |=> out_sample == $past(s1_sample))
    else $error("sample altered with envelope disabled");

endmodule
